FILE: rtl/core/rgtks_pkg.sv
// ----------------------------------------------------------------------------
// rgtks_pkg: shared types and constants for run_grouped_top_k_sum
// Field widths, cell commands and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rgtks_pkg;

  localparam int KEY_W      = 5;
  localparam int VALUE_W    = 30;
  localparam int TC_W       = 6;
  localparam int TOTAL_W    = 63;
  localparam int MAX_K_DEF  = 32;

  localparam int IN_DATA_W  = 40;   // key + value, padded to whole bytes
  localparam int OUT_DATA_W = 64;   // total, padded to whole bytes

  localparam logic [TC_W-1:0]    TC_RESET  = TC_W'(1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [VALUE_W-1:0]  ins_value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_INSERT,
    ST_EMIT
  } seq_state_e;

endpackage

FILE: rtl/core/rgtks_cell.sv
// ----------------------------------------------------------------------------
// rgtks_cell: one slot of the sorted best-values chain
// Compare-and-shift insert, shift toward the head for draining, clear.
// ----------------------------------------------------------------------------
module rgtks_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rgtks_pkg::cell_ctrl_t         ctrl_i,
  input  logic [rgtks_pkg::VALUE_W-1:0] prev_val_i,  // neighbor toward the head
  input  logic                          prev_gt_i,   // neighbor's compare result
  input  logic [rgtks_pkg::VALUE_W-1:0] next_val_i,  // neighbor toward the tail
  output logic [rgtks_pkg::VALUE_W-1:0] val_o,
  output logic                          gt_o
);
  import rgtks_pkg::*;

  logic [VALUE_W-1:0] val_q, val_d;

  // new value beats this slot; chain is sorted so gt is monotone along it
  assign gt_o = ctrl_i.ins_value > val_q;

  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.op)
      CELL_HOLD:   val_d = val_q;
      CELL_INSERT: begin
        if (gt_o) begin
          val_d = prev_gt_i ? prev_val_i : ctrl_i.ins_value;
        end
      end
      CELL_SHIFT:  val_d = next_val_i;
      CELL_CLEAR:  val_d = '0;
      default:     val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

FILE: rtl/core/run_grouped_top_k_sum.sv
// ----------------------------------------------------------------------------
// run_grouped_top_k_sum: sum of the top values of each keyed run
// Sorted compare-and-shift cell chain per run, drained into a saturating total.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready| tdata {pad, value, key}, tlast
//  m_axis    | out | m_axis_tvalid/m_axis_tready| tdata {pad, total}
//  cfg       | in  | cfg_valid_i/cfg_ready_o    | cfg_data_i = top_count
//
//  Items of the open run are taken back to back while the sequencer is idle.
//  A key change stalls the input while the chain shifts its head into the
//  total once per counted value, min(top_count, MAX_K), clears, then inserts
//  the held item. A last item drains the run the same way, then its total is
//  loaded into the output register. Only the single head tap feeds the total.
//  Reset: async, active low; chain, total, run state cleared, top_count = 1.
//  Stalls: the result sits in an output register; while it waits the block
//  keeps taking items, and only a later result waits for the slot.
//
//  Empty slots hold zero, so the sum of the first top_count slots equals the
//  sum over the filled ones; no per-slot valid bits are needed.
//
module run_grouped_top_k_sum #(
  parameter int MAX_K = rgtks_pkg::MAX_K_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input requests
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rgtks_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [4:0] key, [34:5] value
  input  logic                             s_axis_tlast,  // last
  // results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rgtks_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [62:0] total
  // top_count register
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rgtks_pkg::TC_W-1:0]       cfg_data_i
);
  import rgtks_pkg::*;

  localparam int CNT_W = $clog2(MAX_K + 1);

  // input unpack
  logic [KEY_W-1:0]   in_key;
  logic [VALUE_W-1:0] in_value;
  assign in_key   = s_axis_tdata[KEY_W-1:0];
  assign in_value = s_axis_tdata[KEY_W +: VALUE_W];

  // control and run state
  seq_state_e          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q;
  logic                pend_q;
  logic [KEY_W-1:0]    hold_key_q;
  logic [VALUE_W-1:0]  hold_val_q;
  logic                hold_last_q;
  logic [KEY_W-1:0]    cur_key_q;
  logic                run_open_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [TC_W-1:0]     top_count_q;
  logic                out_valid_q;
  logic [TOTAL_W-1:0]  out_data_q;

  logic                in_fire, need_close, emit_ok;
  logic [CNT_W-1:0]    lim;
  cell_ctrl_t          ctrl;

  // chain
  logic [VALUE_W-1:0]  cell_val [MAX_K];
  logic                cell_gt  [MAX_K];

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign need_close = run_open_q && (in_key != cur_key_q);
  assign emit_ok    = !out_valid_q || m_axis_tready;
  // top_count clamped to the chain length
  assign lim = (int'(top_count_q) > MAX_K) ? CNT_W'(MAX_K) : CNT_W'(top_count_q);

  // saturating add of the chain head into the total
  logic [TOTAL_W:0]   acc_sum;
  logic [TOTAL_W-1:0] acc_sat;
  assign acc_sum = {1'b0, total_q} + (TOTAL_W + 1)'(cell_val[0]);
  assign acc_sat = acc_sum[TOTAL_W] ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (need_close || s_axis_tlast)) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (cnt_q == '0) begin
          state_d = pend_q ? ST_INSERT : ST_EMIT;
        end
      end
      ST_INSERT: state_d = hold_last_q ? ST_CLOSE : ST_IDLE;
      ST_EMIT: begin
        if (emit_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- outputs of the sequencer: chain command and input ready ----
  always_comb begin
    ctrl.op        = CELL_HOLD;
    ctrl.ins_value = in_value;
    s_axis_tready  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        // ready is high here, so tvalid alone marks an accepted request
        if (s_axis_tvalid && !need_close) begin
          ctrl.op = CELL_INSERT;
        end
      end
      ST_CLOSE:  ctrl.op = (cnt_q != '0) ? CELL_SHIFT : CELL_CLEAR;
      ST_INSERT: begin
        ctrl.op        = CELL_INSERT;
        ctrl.ins_value = hold_val_q;
      end
      ST_EMIT:   ctrl.op = CELL_HOLD;
      default:   ctrl.op = CELL_HOLD;
    endcase
  end

  // ---- cell chain: head (index 0) holds the largest value ----
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic [VALUE_W-1:0] prev_val, next_val;
    logic               prev_gt;
    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end
    if (i == MAX_K - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end
    rgtks_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i])
    );
  end

  // ---- state register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- run bookkeeping and total ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      cur_key_q  <= '0;
      run_open_q <= 1'b0;
      total_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (need_close) begin
              cnt_q  <= lim;
              pend_q <= 1'b1;
            end else begin
              cur_key_q  <= in_key;
              run_open_q <= 1'b1;
              pend_q     <= 1'b0;
              if (s_axis_tlast) begin
                cnt_q <= lim;
              end
            end
          end
        end
        ST_CLOSE: begin
          if (cnt_q != '0) begin
            cnt_q   <= cnt_q - CNT_W'(1);
            total_q <= acc_sat;
          end else begin
            run_open_q <= 1'b0;
          end
        end
        ST_INSERT: begin
          cur_key_q  <= hold_key_q;
          run_open_q <= 1'b1;
          pend_q     <= 1'b0;
          if (hold_last_q) begin
            cnt_q <= lim;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            total_q   <= '0;
            cur_key_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // held item while the previous run drains
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire && need_close) begin
      hold_key_q  <= in_key;
      hold_val_q  <= in_value;
      hold_last_q <= s_axis_tlast;
    end
  end

  // ---- top_count register ----
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= TC_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      top_count_q <= cfg_data_i;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && emit_ok) begin
      out_data_q <= total_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - TOTAL_W){1'b0}}, out_data_q};

`ifndef SYNTH
  // chain stays sorted, largest first
  for (genvar j = 0; j < MAX_K - 1; j++) begin : g_chk_sorted
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cell_val[j] >= cell_val[j+1])
      else $error("best-value chain out of order");
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= MAX_K)
    else $error("drain count beyond chain length");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && emit_ok) |=>
      (total_q == '0 && m_axis_tvalid && out_data_q == $past(total_q)))
    else $error("emitted total not loaded or total not cleared");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for run_grouped_top_k_sum
// Drives keyed value streams with random pacing and top_count settings, and
// checks every emitted total against an in-bench top-k predictor.
// ----------------------------------------------------------------------------
module testbench;
  import rgtks_pkg::*;

  localparam int MAX_K        = MAX_K_DEF;
  localparam int HOLD_CYCLES  = 300;   // long output hold-off for back-pressure
  localparam int SETTLE       = 100;   // outlasts the worst close/drain pass
  localparam int STALL_LIMIT  = 3000;  // cycles with no request moving at all
  localparam int PHASE_ITEMS  = 95;

  // --------------------------------------------------------------------------
  // Predictor and expected-total store
  // --------------------------------------------------------------------------
  class topk_sum_scoreboard;
    logic [TC_W-1:0]    top_count;
    logic [VALUE_W-1:0] best [MAX_K];  // largest values of the open run, descending
    int                 best_cnt;
    logic [KEY_W-1:0]   run_key;
    bit                 run_open;
    logic [TOTAL_W-1:0] grand;
    logic [TOTAL_W-1:0] expected_totals [$];
    int                 errors;
    int                 n_requests;
    int                 n_totals;
    int                 n_cfg;

    function new();
      top_count = TC_RESET;
      clear_run();
      run_key  = '0;
      run_open = 1'b0;
      grand    = '0;
    endfunction

    function void clear_run();
      foreach (best[i]) best[i] = '0;
      best_cnt = 0;
    endfunction

    function void set_top_count(logic [TC_W-1:0] v);
      top_count = v;
      n_cfg++;
    endfunction

    // sorted insert; a full list drops anything not above its smallest entry
    function void insert_value(logic [VALUE_W-1:0] v);
      int pos;
      if (best_cnt < MAX_K) begin
        pos = best_cnt;
        best_cnt++;
      end else begin
        if (v <= best[MAX_K-1]) return;
        pos = MAX_K - 1;
      end
      while (pos > 0 && best[pos-1] < v) begin
        best[pos] = best[pos-1];
        pos--;
      end
      best[pos] = v;
    endfunction

    // top_count as it stands at close time decides the run's share
    function void close_run();
      int          lim;
      logic [63:0] run_total;
      logic [63:0] acc;
      if (run_open) begin
        lim = (top_count > MAX_K) ? MAX_K : int'(top_count);
        if (lim > best_cnt) lim = best_cnt;
        run_total = '0;
        for (int i = 0; i < lim; i++) run_total += 64'(best[i]);
        acc = {1'b0, grand} + run_total;
        grand = (acc > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : acc[TOTAL_W-1:0];
      end
      clear_run();
      run_open = 1'b0;
    endfunction

    function void note_request(logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                               logic last);
      n_requests++;
      if (run_open && key != run_key) close_run();
      insert_value(value);
      run_key  = key;
      run_open = 1'b1;
      if (last) begin
        close_run();
        expected_totals = {expected_totals, grand};
        grand   = '0;
        run_key = '0;
      end
    endfunction

    function void check_total(logic [OUT_DATA_W-1:0] data);
      logic [TOTAL_W-1:0] exp_total;
      if (expected_totals.size() == 0) begin
        $error("total: no total expected, actual %0d", data[TOTAL_W-1:0]);
        errors++;
      end else begin
        exp_total = expected_totals.pop_front();
        n_totals++;
        if (data[TOTAL_W-1:0] !== exp_total) begin
          $error("total: expected %0d, actual %0d", exp_total, data[TOTAL_W-1:0]);
          errors++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [4:0] key, [34:5] value
  logic                  s_axis_tlast  = 1'b0; // last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [62:0] total
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [TC_W-1:0]       cfg_data_i    = '0;

  topk_sum_scoreboard sb;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req_cnt  = 0;   // bumped by stimulus; receiver starts a hold-off on change
  int items_sent    = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  run_grouped_top_k_sum dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Monitor: samples at the edge, so it sees pre-edge values of both sides.
  // Input is noted before the result check; a result never leaves in the
  // cycle its last request enters, so the queue order is unaffected.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_top_count(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W +: VALUE_W],
                        s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_total(m_axis_tdata);
    end
  end

  // Receiver: random stalls, plus a counted hold-off when requested.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any handshake on any channel resets the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // tvalid stays high between back-to-back requests; only idle gaps lower it
  task automatic send_item(logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                           logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, value, key};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // drain all expected totals, then let any close/drain pass finish
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_totals.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_top_count(logic [TC_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 12)      return '0;
    else if (sel < 24) return '1;
    else if (sel < 40) return VALUE_W'($urandom_range(15));   // lots of ties
    else               return VALUE_W'($urandom);
  endfunction

  // zero, small, around MAX_K and the saturating top end
  function automatic logic [TC_W-1:0] pick_top_count();
    int sel;
    sel = $urandom_range(11);
    case (sel)
      0:       return TC_W'(0);
      1:       return TC_W'(1);
      2:       return TC_W'(2);
      3:       return TC_W'(3);
      4:       return TC_W'(5);
      5:       return TC_W'(8);
      6:       return TC_W'(31);
      7:       return TC_W'(MAX_K);
      8:       return TC_W'(MAX_K + 1);
      9:       return '1;
      default: return TC_W'($urandom);
    endcase
  endfunction

  // One stream: a few keyed runs, the final request flagged last. Runs are
  // mostly short; now and then one overflows the sorted list.
  task automatic run_stream(bit allow_cfg);
    int               n_runs;
    int               run_len;
    logic [KEY_W-1:0] key;
    if (allow_cfg && $urandom_range(1)) begin
      wait_quiet();
      write_top_count(pick_top_count());
    end
    n_runs = $urandom_range(1, 3);
    for (int r = 0; r < n_runs; r++) begin
      // top_count change while a run is open
      if (allow_cfg && r > 0 && $urandom_range(99) < 8) begin
        wait_quiet();
        write_top_count(pick_top_count());
      end
      key     = KEY_W'($urandom);
      run_len = (allow_cfg && $urandom_range(99) < 5) ? $urandom_range(MAX_K + 1, MAX_K + 8)
                                                      : $urandom_range(1, 3);
      for (int i = 0; i < run_len; i++)
        send_item(key, pick_value(), (r == n_runs - 1) && (i == run_len - 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int send_pcts [4];
    int recv_pcts [4];
    int phase_base;
    send_pcts = '{0, 54, 0, 23};
    recv_pcts = '{0, 0, 54, 23};
    sb = new();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed. Reset top_count of one: largest per run, keys zero and 31.
    send_item(5'd0,  '0,         1'b0);
    send_item(5'd0,  '1,         1'b0);
    send_item(5'd31, 30'd5,      1'b0);
    send_item(5'd31, 30'd7,      1'b1);
    // zero top_count: every run adds nothing
    wait_quiet();
    write_top_count(TC_W'(0));
    send_item(5'd3,  30'd100,    1'b0);
    send_item(5'd4,  30'd200,    1'b1);
    // top_count above MAX_K behaves as MAX_K
    wait_quiet();
    write_top_count('1);
    send_item(5'd10, '1,         1'b0);
    send_item(5'd10, '1,         1'b0);
    send_item(5'd10, 30'd1,      1'b0);
    send_item(5'd10, '0,         1'b1);
    // top_count lowered mid-run: the value at close applies
    wait_quiet();
    write_top_count(TC_W'(2));
    send_item(5'd7,  30'd10,     1'b0);
    send_item(5'd7,  30'd30,     1'b0);
    send_item(5'd7,  30'd20,     1'b0);
    wait_quiet();
    write_top_count(TC_W'(1));
    send_item(5'd7,  30'd5,      1'b1);
    // single-request streams, alternating bit patterns, top_count at MAX_K
    wait_quiet();
    write_top_count(TC_W'(MAX_K));
    send_item(5'd21, 30'h2AAAAAAA, 1'b1);
    send_item(5'd10, 30'h15555555, 1'b1);
    // a fresh stream right after an emit, starting on key zero
    send_item(5'd0,  30'd9,      1'b1);

    // Random: four pacing phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pcts[p];
      recv_idle_pct = recv_pcts[p];
      phase_base    = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS) run_stream(1'b1);
    end

    // Back-pressure: hold the output off while short streams keep coming,
    // so the result slot fills and the input stalls.
    wait_quiet();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (12) run_stream(1'b0);

    wait_quiet();

    $display("summary: %0d requests, %0d totals checked, %0d top_count writes",
             sb.n_requests, sb.n_totals, sb.n_cfg);
    $display("summary: four stall mixes plus a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (sb.errors == 0 && sb.expected_totals.size() == 0) begin
      $display("testbench: clean");
    end else begin
      if (sb.expected_totals.size() != 0)
        $error("total: %0d expected totals never arrived", sb.expected_totals.size());
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
